FILE: design/gmt_pkg.sv
// Shared constants, types and the vocabulary ROM for the longest-match tokenizer.
`default_nettype none

package gmt_pkg;

    localparam int WINDOW_LEN  = 10;
    localparam int VOCAB_WORDS = 31;
    localparam int WORD_MAX    = 8;
    localparam int WORD_BITS   = WORD_MAX * 8;
    localparam int CNT_W       = $clog2(WINDOW_LEN + 1);
    localparam int LEN_W       = $clog2(WORD_MAX + 1);
    localparam int VIDX_W      = $clog2(VOCAB_WORDS);

    localparam logic [7:0] SEP_BYTE = 8'd124;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SEP,
        ST_EMIT
    } gmt_state_t;

    // Per-cell window control
    typedef struct packed {
        logic shift;
        logic load;
    } gmt_cell_ctrl_t;

    // Vocabulary entry: text right-justified, first char in the top used byte
    typedef struct packed {
        logic [WORD_BITS-1:0] text;
        logic [LEN_W-1:0]     len;
    } vocab_t;

    function automatic vocab_t vocab_entry(input logic [VIDX_W-1:0] w);
        vocab_t e;
        e.text = '0;
        e.len  = '0;
        unique case (w)
            5'd0:  begin e.text = WORD_BITS'("the");      e.len = LEN_W'(3); end
            5'd1:  begin e.text = WORD_BITS'("a");        e.len = LEN_W'(1); end
            5'd2:  begin e.text = WORD_BITS'("an");       e.len = LEN_W'(2); end
            5'd3:  begin e.text = WORD_BITS'("in");       e.len = LEN_W'(2); end
            5'd4:  begin e.text = WORD_BITS'("on");       e.len = LEN_W'(2); end
            5'd5:  begin e.text = WORD_BITS'("at");       e.len = LEN_W'(2); end
            5'd6:  begin e.text = WORD_BITS'("to");       e.len = LEN_W'(2); end
            5'd7:  begin e.text = WORD_BITS'("from");     e.len = LEN_W'(4); end
            5'd8:  begin e.text = WORD_BITS'("with");     e.len = LEN_W'(4); end
            5'd9:  begin e.text = WORD_BITS'("and");      e.len = LEN_W'(3); end
            5'd10: begin e.text = WORD_BITS'("or");       e.len = LEN_W'(2); end
            5'd11: begin e.text = WORD_BITS'("but");      e.len = LEN_W'(3); end
            5'd12: begin e.text = WORD_BITS'("hello");    e.len = LEN_W'(5); end
            5'd13: begin e.text = WORD_BITS'("world");    e.len = LEN_W'(5); end
            5'd14: begin e.text = WORD_BITS'("data");     e.len = LEN_W'(4); end
            5'd15: begin e.text = WORD_BITS'("token");    e.len = LEN_W'(5); end
            5'd16: begin e.text = WORD_BITS'("model");    e.len = LEN_W'(5); end
            5'd17: begin e.text = WORD_BITS'("language"); e.len = LEN_W'(8); end
            5'd18: begin e.text = WORD_BITS'("process");  e.len = LEN_W'(7); end
            5'd19: begin e.text = WORD_BITS'("system");   e.len = LEN_W'(6); end
            5'd20: begin e.text = WORD_BITS'("lab");      e.len = LEN_W'(3); end
            5'd21: begin e.text = WORD_BITS'("ios");      e.len = LEN_W'(3); end
            5'd22: begin e.text = WORD_BITS'("ch");       e.len = LEN_W'(2); end
            5'd23: begin e.text = WORD_BITS'("ar");       e.len = LEN_W'(2); end
            5'd24: begin e.text = WORD_BITS'("er");       e.len = LEN_W'(2); end
            5'd25: begin e.text = WORD_BITS'("ing");      e.len = LEN_W'(3); end
            5'd26: begin e.text = WORD_BITS'("ed");       e.len = LEN_W'(2); end
            5'd27: begin e.text = WORD_BITS'("s");        e.len = LEN_W'(1); end
            5'd28: begin e.text = WORD_BITS'("es");       e.len = LEN_W'(2); end
            5'd29: begin e.text = WORD_BITS'("ly");       e.len = LEN_W'(2); end
            5'd30: begin e.text = WORD_BITS'("ment");     e.len = LEN_W'(4); end
            default: begin e.text = '0; e.len = '0; end
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: design/gmt_cell.sv
// One window cell: holds a byte, loads from the input or takes its right neighbour's byte.
`default_nettype none

module gmt_cell (
    input  wire logic                    clk,
    input  wire gmt_pkg::gmt_cell_ctrl_t ctrl,
    input  wire logic [7:0]              new_byte,
    input  wire logic [7:0]              right_byte,
    output logic [7:0]                   cell_byte
);
    import gmt_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift)
        begin
            byte_next = right_byte;
        end
        else if (ctrl.load)
        begin
            byte_next = new_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

`default_nettype wire

FILE: design/gmt_match.sv
// Longest vocabulary prefix of the window front, limited to the bytes held; 1 if none.
`default_nettype none

module gmt_match (
    input  wire logic [7:0]                  win [gmt_pkg::WINDOW_LEN],
    input  wire logic [gmt_pkg::CNT_W-1:0]   avail,
    output logic [gmt_pkg::LEN_W-1:0]        match_len
);
    import gmt_pkg::*;

    always_comb
    begin
        logic [WORD_MAX:0] hit;
        vocab_t            e;
        logic              eq;
        int                pos;
        hit       = '0;
        e         = '0;
        eq        = 1'b0;
        pos       = 0;
        match_len = LEN_W'(1);
        for (int w = 0; w < VOCAB_WORDS; w++)
        begin
            e  = vocab_entry(VIDX_W'(w));
            eq = 1'b1;
            for (int k = 0; k < WORD_MAX; k++)
            begin
                pos = int'(e.len) - 1 - k;
                if (pos >= 0 && win[k] != e.text[pos*8 +: 8])
                begin
                    eq = 1'b0;
                end
            end
            if (eq && (CNT_W'(e.len) <= avail))
            begin
                hit[e.len] = 1'b1;
            end
        end
        for (int l = 2; l <= WORD_MAX; l++)
        begin
            if (hit[l])
            begin
                match_len = LEN_W'(l);
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/greedy_longest_match_tokenizer_unit.sv
// Top level: greedy longest-match tokenizer with a shifting window of byte cells.
//
//  channel | valid     | stall     | fields              | beat
//  --------+-----------+-----------+---------------------+------------------------------
//  in      | in_valid  | in_stall  | in_byte, in_last    | one text byte
//  out     | out_valid | out_stall | out_byte, out_last  | one text byte or '|' separator
//
//  Input bytes are taken while idle. Each cut token then passes a match step, a separator
//  (all tokens but the first of a text) and its bytes; the token leaves the window cells
//  one byte per cycle while the output is not stalled. in_stall is high while cutting.
//  Reset clears the control state only; the window bytes are read below the count.
//  A stalled output holds its beat and freezes token emission until taken.
`default_nettype none

module greedy_longest_match_tokenizer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import gmt_pkg::*;

    gmt_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;     // bytes held in the window
    logic [LEN_W-1:0]  tok_reg, tok_next;         // bytes of the token still to go
    logic              flush_reg, flush_next;     // final byte seen, draining
    logic              emitted_reg, emitted_next; // a token of this text is out
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic              olast_reg, olast_next;

    logic [7:0]        win [WINDOW_LEN];
    gmt_cell_ctrl_t    ctrl [WINDOW_LEN];
    logic [LEN_W-1:0]  match_len;
    logic              in_take;
    logic              out_free;
    logic              shift;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !ovalid_reg || !out_stall;

    // Window: a row of cells shifting towards the front by one byte per emit
    for (genvar i = 0; i < WINDOW_LEN; i++)
    begin : g_cell
        logic [7:0] right;
        if (i == WINDOW_LEN - 1)
        begin : g_end
            assign right = 8'h00;
        end
        else
        begin : g_mid
            assign right = win[i+1];
        end

        assign ctrl[i].shift = shift;
        assign ctrl[i].load  = in_take && (count_reg == CNT_W'(i));

        gmt_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[i]),
            .new_byte   (in_byte),
            .right_byte (right),
            .cell_byte  (win[i])
        );
    end

    gmt_match u_match (
        .win       (win),
        .avail     (count_reg),
        .match_len (match_len)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        tok_next     = tok_reg;
        flush_next   = flush_reg;
        emitted_next = emitted_reg;
        ovalid_next  = ovalid_reg && out_stall;
        obyte_next   = obyte_reg;
        olast_next   = olast_reg;
        shift        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (in_last)
                    begin
                        flush_next = 1'b1;
                        state_next = ST_MATCH;
                    end
                    else if (count_reg == CNT_W'(WINDOW_LEN - 1))
                    begin
                        state_next = ST_MATCH;
                    end
                end
            end
            ST_MATCH:
            begin
                tok_next   = match_len;
                state_next = emitted_reg ? ST_SEP : ST_EMIT;
            end
            ST_SEP:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = SEP_BYTE;
                    olast_next  = 1'b0;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next  = 1'b1;
                    obyte_next   = win[0];
                    olast_next   = flush_reg && (count_reg == CNT_W'(1));
                    shift        = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                    tok_next     = tok_reg - LEN_W'(1);
                    emitted_next = 1'b1;
                    if (tok_reg == LEN_W'(1))
                    begin
                        if (flush_reg && (count_reg != CNT_W'(1)))
                        begin
                            state_next = ST_MATCH;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                            if (flush_reg)
                            begin
                                flush_next   = 1'b0;
                                emitted_next = 1'b0;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            tok_reg     <= '0;
            flush_reg   <= 1'b0;
            emitted_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tok_reg     <= tok_next;
            flush_reg   <= flush_next;
            emitted_reg <= emitted_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

endmodule

`default_nettype wire
